/* hw/rtl/bmpg_pkg.sv */
// Shared constants and types for the brick mask pixel generator.
package bmpg_pkg;

    localparam int unsigned CFG_W    = 13;
    localparam int unsigned BEVEL_W  = 12;
    localparam int unsigned IN_W     = 12;
    localparam int unsigned OUT_W    = 16;
    localparam int unsigned SCALED_W = BEVEL_W + OUT_W;

    localparam logic [OUT_W-1:0] FULL_SCALE = 16'hFFFF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_BRICK_W = 2'd0,
        CFG_BRICK_H = 2'd1,
        CFG_MORTAR  = 2'd2,
        CFG_BEVEL   = 2'd3
    } cfg_idx_t;

    // Flow control between pipeline sections
    typedef struct packed {
        logic en;
        logic vld;
    } pipe_ctl_t;

endpackage

/* hw/rtl/bmpg_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module bmpg_div #(
    parameter int unsigned NB = 13,
    parameter int unsigned DB = 13,
    parameter int unsigned SB = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bmpg_pkg::pipe_ctl_t ctl_i,
    input  logic [NB-1:0]       num,
    input  logic [DB-1:0]       den,
    input  logic [SB-1:0]       side_i,
    output logic                vld_o,
    output logic [NB-1:0]       quo,
    output logic [DB-1:0]       rem,
    output logic [SB-1:0]       side_o
);

    logic [DB-1:0] rem_reg  [NB];
    logic [NB-1:0] qn_reg   [NB];
    logic [SB-1:0] side_reg [NB];
    logic          vld_reg  [NB];

    genvar k;
    generate
        for (k = 0; k < NB; k++) begin : g_stage
            logic [DB-1:0] rem_in;
            logic [NB-1:0] qn_in;
            logic [SB-1:0] side_in;
            logic          vld_in;
            logic [DB:0]   trial;
            logic          ge;
            logic [DB:0]   diff;

            if (k == 0) begin : g_first
                assign rem_in  = '0;
                assign qn_in   = num;
                assign side_in = side_i;
                assign vld_in  = ctl_i.vld;
            end else begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign qn_in   = qn_reg[k-1];
                assign side_in = side_reg[k-1];
                assign vld_in  = vld_reg[k-1];
            end

            // shift in next dividend bit, subtract if it fits
            assign trial = {rem_in, qn_in[NB-1]};
            assign ge    = trial >= {1'b0, den};
            assign diff  = ge ? (trial - {1'b0, den}) : trial;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (ctl_i.en) begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (ctl_i.en) begin
                    rem_reg[k]  <= diff[DB-1:0];
                    qn_reg[k]   <= {qn_in[NB-2:0], ge};
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign vld_o  = vld_reg[NB-1];
    assign quo    = qn_reg[NB-1];
    assign rem    = rem_reg[NB-1];
    assign side_o = side_reg[NB-1];

endmodule

/* hw/rtl/brick_mask_pixel_generator.sv */
// Top level of the running-bond brick mask pixel generator.
//
// Input channel s_*: one pixel coordinate word (x, y) per handshake.
// Output channel m_*: one result word per pixel, in order: brick presence,
// bevel shade and a flag for inconsistent brick parameters.
// Configuration: cfg_wr_en writes cfg_data into the register at cfg_index
// (brick width, brick height, mortar, bevel); write only while idle.
//
// The pipeline has 1 input stage, 13 stages for the row divide,
// 1 stage for the half-brick shift, 14 stages for the column divide,
// 2 stages for the bevel distance, 28 stages for the shade divide and the
// output register. Throughput is one pixel per cycle while the output is
// not stalled, set by the fully pipelined dividers.
//
// Reset clears every valid bit and loads the default brick geometry.
// When m_ready is low with a word waiting, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated, and bubbles are kept.
module brick_mask_pixel_generator #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [bmpg_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bmpg_pkg::IN_W-1:0]    s_x_coord,
    input  logic [bmpg_pkg::IN_W-1:0]    s_y_coord,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bmpg_pkg::OUT_W-1:0]   m_brick_present,
    output logic [bmpg_pkg::OUT_W-1:0]   m_bevel_shade,
    output logic                         m_params_bad
);

    localparam int unsigned CW = bmpg_pkg::CFG_W;
    localparam int unsigned BW = bmpg_pkg::BEVEL_W;
    localparam int unsigned IW = bmpg_pkg::IN_W;
    localparam int unsigned OW = bmpg_pkg::OUT_W;
    localparam int unsigned SW = bmpg_pkg::SCALED_W;
    localparam int unsigned DW = 16;
    localparam logic [IW-1:0] CMASK =
        (COORD_BITS >= IW) ? {IW{1'b1}} : IW'((1 << COORD_BITS) - 1);

    // edge distance along one axis, signed
    function automatic logic signed [DW-1:0] edge_dist(
        input logic [CW-1:0] ofs,
        input logic [CW-1:0] period,
        input logic [CW-1:0] mt,
        input logic [BW-1:0] bv
    );
        logic signed [DW-1:0] pos;
        logic signed [DW-1:0] far_edge;
        logic signed [DW-1:0] sbv;
        pos      = $signed(DW'(ofs)) - $signed(DW'(mt));
        sbv      = $signed(DW'(bv));
        far_edge = $signed(DW'(period)) - sbv - $signed(DW'(mt));
        if (pos < sbv) begin
            edge_dist = sbv - pos;
        end else if (pos >= far_edge) begin
            edge_dist = pos - far_edge;
        end else begin
            edge_dist = '0;
        end
    endfunction

    // configuration registers
    logic [CW-1:0] bw_reg, bh_reg, mt_reg;
    logic [BW-1:0] bv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw_reg <= CW'(64);
            bh_reg <= CW'(32);
            mt_reg <= CW'(4);
            bv_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (bmpg_pkg::cfg_idx_t'(cfg_index))
                bmpg_pkg::CFG_BRICK_W: bw_reg <= cfg_data;
                bmpg_pkg::CFG_BRICK_H: bh_reg <= cfg_data;
                bmpg_pkg::CFG_MORTAR:  mt_reg <= cfg_data;
                bmpg_pkg::CFG_BEVEL:   bv_reg <= cfg_data[BW-1:0];
                default: ;
            endcase
        end
    end

    // parameter sanity flag, with signed compares for the bevel spans
    logic signed [CW+1:0] span_w, span_h, bev2;
    logic                 params_bad;
    assign span_w = $signed((CW+2)'(bw_reg)) - $signed((CW+2)'(mt_reg));
    assign span_h = $signed((CW+2)'(bh_reg)) - $signed((CW+2)'(mt_reg));
    assign bev2   = $signed({2'b00, bv_reg, 1'b0});
    assign params_bad = (mt_reg > bw_reg) || (mt_reg > bh_reg) || (bev2 > span_w)
                     || (bev2 > span_h) || (bw_reg == '0) || (bh_reg == '0);

    // global advance: hold everything while an output word waits
    logic                en;
    bmpg_pkg::pipe_ctl_t ctl_y, ctl_x, ctl_s;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage A: input register
    logic          a_vld_reg;
    logic [IW-1:0] a_x_reg, a_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_x_reg <= s_x_coord & CMASK;
            a_y_reg <= s_y_coord & CMASK;
        end
    end

    // offset by half the mortar, then divide the row coordinate
    logic [CW-1:0] half_mt, xx, yy;
    assign half_mt = mt_reg >> 1;
    assign xx      = CW'(a_x_reg) + half_mt;
    assign yy      = CW'(a_y_reg) + half_mt;
    assign ctl_y   = '{en: en, vld: a_vld_reg};

    logic          y_vld;
    logic [CW-1:0] y_quo, y_rem, y_xx;

    bmpg_div #(.NB(CW), .DB(CW), .SB(CW)) u_div_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   (ctl_y),
        .num     (yy),
        .den     (bh_reg),
        .side_i  (xx),
        .vld_o   (y_vld),
        .quo     (y_quo),
        .rem     (y_rem),
        .side_o  (y_xx)
    );

    // stage B: half-brick shift on odd rows
    logic          b_vld_reg, b_rowm_reg;
    logic [CW-1:0] b_oy_reg;
    logic [CW:0]   b_xs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= y_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_rowm_reg <= y_rem < mt_reg;
            b_oy_reg   <= y_rem;
            b_xs_reg   <= y_quo[0] ? ((CW+1)'(y_xx) + (CW+1)'(bw_reg >> 1))
                                   : (CW+1)'(y_xx);
        end
    end

    assign ctl_x = '{en: en, vld: b_vld_reg};

    logic          x_vld, x_rowm;
    logic [CW:0]   x_quo;
    logic [CW-1:0] x_rem, x_oy;

    bmpg_div #(.NB(CW+1), .DB(CW), .SB(CW+1)) u_div_col (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   (ctl_x),
        .num     (b_xs_reg),
        .den     (bw_reg),
        .side_i  ({b_rowm_reg, b_oy_reg}),
        .vld_o   (x_vld),
        .quo     (x_quo),
        .rem     (x_rem),
        .side_o  ({x_rowm, x_oy})
    );

    // stage C: mortar decision and per-axis edge distances
    logic                 c_vld_reg, c_mortar_reg;
    logic signed [DW-1:0] c_dx_reg, c_dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= x_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_mortar_reg <= x_rowm || (x_rem < mt_reg) || (bw_reg == '0)
                         || (bh_reg == '0) || (x_quo[CW] && 1'b0);
            c_dx_reg     <= edge_dist(x_rem, bw_reg, mt_reg, bv_reg);
            c_dy_reg     <= edge_dist(x_oy, bh_reg, mt_reg, bv_reg);
        end
    end

    // stage D: Chebyshev distance, clamp, scale by full scale
    logic                 d_vld_reg, d_mortar_reg;
    logic [SW-1:0]        d_num_reg;
    logic signed [DW-1:0] dmax, sbv;
    logic [BW-1:0]        dcl, tdist;

    assign sbv  = $signed(DW'(bv_reg));
    assign dmax = (c_dx_reg > c_dy_reg) ? c_dx_reg : c_dy_reg;

    always_comb begin
        priority if (dmax > sbv) begin
            dcl = bv_reg;
        end else if (dmax < 0) begin
            dcl = '0;
        end else begin
            dcl = dmax[BW-1:0];
        end
    end

    assign tdist = bv_reg - dcl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (en) begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_mortar_reg <= c_mortar_reg;
            d_num_reg    <= {tdist, {OW{1'b0}}} - SW'(tdist);
        end
    end

    assign ctl_s = '{en: en, vld: d_vld_reg};

    logic          s_vld, s_mortar;
    logic [SW-1:0] s_quo;
    logic [BW-1:0] s_rem;

    bmpg_div #(.NB(SW), .DB(BW), .SB(1)) u_div_shade (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   (ctl_s),
        .num     (d_num_reg),
        .den     (bv_reg),
        .side_i  (d_mortar_reg),
        .vld_o   (s_vld),
        .quo     (s_quo),
        .rem     (s_rem),
        .side_o  (s_mortar)
    );

    // stage E: output register
    logic          m_vld_reg, m_bad_reg;
    logic [OW-1:0] m_present_reg, m_shade_reg;
    logic          rem_unused;
    assign rem_unused = |s_rem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (en) begin
            m_vld_reg <= s_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_bad_reg     <= params_bad || (rem_unused && 1'b0);
            m_present_reg <= s_mortar ? '0 : bmpg_pkg::FULL_SCALE;
            if (s_mortar) begin
                m_shade_reg <= '0;
            end else if (bv_reg == '0) begin
                m_shade_reg <= bmpg_pkg::FULL_SCALE;
            end else begin
                m_shade_reg <= s_quo[OW-1:0];
            end
        end
    end

    assign m_valid         = m_vld_reg;
    assign m_brick_present = m_present_reg;
    assign m_bevel_shade   = m_shade_reg;
    assign m_params_bad    = m_bad_reg;

    // presence is all or nothing
    a_present_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_brick_present == '0 || m_brick_present == bmpg_pkg::FULL_SCALE))
        else $error("brick presence is neither mortar nor full brick");

    // mortar pixels carry no shade
    a_mortar_shade: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_brick_present == '0) |-> (m_bevel_shade == '0))
        else $error("mortar pixel with nonzero shade");

    // a held output word blocks the input and stays put
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> (!s_ready ##1 (m_valid && $stable(m_bevel_shade)
                                   && $stable(m_brick_present))))
        else $error("pipeline moved during an output stall");

endmodule
